// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define SHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/shd_pkg.sv =====
package shd_pkg;

    typedef logic [2:0] t_pos;
    typedef logic [7:0] t_byte;

    // Header bytes
    localparam t_byte HDR_FIRST  = 8'hAA;
    localparam t_byte HDR_SECOND = 8'h55;
    // Flag value that marks a valid target
    localparam t_byte FLAG_TARGET = 8'd1;

    // Byte positions within a frame
    localparam t_pos POS_HUNT = 3'd0;
    localparam t_pos POS_HDR2 = 3'd1;
    localparam t_pos POS_FLAG = 3'd2;
    localparam t_pos POS_XLO  = 3'd3;
    localparam t_pos POS_XHI  = 3'd4;
    localparam t_pos POS_YLO  = 3'd5;
    localparam t_pos POS_YHI  = 3'd6;
    localparam t_pos POS_CSUM = 3'd7;

    typedef struct packed {
        logic               target_valid;
        logic signed [15:0] x_position;
        logic [15:0]        y_position;
        logic [31:0]        frame_count;
    } t_result;

    typedef struct packed {
        logic last; // checksum byte is next
        logic good; // checksum matched on this beat
    } t_asm_status;

endpackage

// ===== rtl/core/shd_if.sv =====
interface shd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source  (output valid, output rx_byte, input ready);
    modport sink    (input valid, input rx_byte, output ready);
    modport monitor (input valid, input rx_byte, input ready);
endinterface

interface shd_res_if;
    logic               valid;
    logic               ready;
    logic               target_valid;
    logic signed [15:0] x_position;
    logic [15:0]        y_position;
    logic [31:0]        frame_count;

    modport source (output valid, output target_valid, output x_position,
                    output y_position, output frame_count, input ready);
    modport sink   (input valid, input target_valid, input x_position,
                    input y_position, input frame_count, output ready);
    modport monitor (input valid, input target_valid, input x_position,
                     input y_position, input frame_count, input ready);
endinterface

// ===== rtl/core/shd_frame_asm.sv =====
module shd_frame_asm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  shd_pkg::t_byte       i_byte,
    output shd_pkg::t_asm_status o_status,
    output shd_pkg::t_result     o_result
);

    shd_pkg::t_pos  r_pos,   n_pos;
    shd_pkg::t_byte r_sum,   n_sum;
    shd_pkg::t_byte r_flag,  n_flag;
    logic [15:0]    r_x,     n_x;
    logic [15:0]    r_y,     n_y;
    logic [31:0]    r_total, n_total;
    logic           w_good;

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_flag  = r_flag;
        n_x     = r_x;
        n_y     = r_y;
        n_total = r_total;
        w_good  = 1'b0;
        if (i_accept) begin
            case (r_pos)
                shd_pkg::POS_HUNT: begin
                    if (i_byte == shd_pkg::HDR_FIRST) begin
                        n_pos = shd_pkg::POS_HDR2;
                        n_sum = i_byte;
                    end
                end
                shd_pkg::POS_HDR2: begin
                    if (i_byte == shd_pkg::HDR_SECOND) begin
                        n_pos = shd_pkg::POS_FLAG;
                        n_sum = r_sum + i_byte;
                    end else if (i_byte == shd_pkg::HDR_FIRST) begin
                        n_sum = i_byte; // restart header
                    end else begin
                        n_pos = shd_pkg::POS_HUNT;
                    end
                end
                shd_pkg::POS_FLAG: begin
                    n_flag = i_byte;
                    n_sum  = r_sum + i_byte;
                    n_pos  = shd_pkg::POS_XLO;
                end
                shd_pkg::POS_XLO: begin
                    n_x[7:0] = i_byte;
                    n_sum    = r_sum + i_byte;
                    n_pos    = shd_pkg::POS_XHI;
                end
                shd_pkg::POS_XHI: begin
                    n_x[15:8] = i_byte;
                    n_sum     = r_sum + i_byte;
                    n_pos     = shd_pkg::POS_YLO;
                end
                shd_pkg::POS_YLO: begin
                    n_y[7:0] = i_byte;
                    n_sum    = r_sum + i_byte;
                    n_pos    = shd_pkg::POS_YHI;
                end
                shd_pkg::POS_YHI: begin
                    n_y[15:8] = i_byte;
                    n_sum     = r_sum + i_byte;
                    n_pos     = shd_pkg::POS_CSUM;
                end
                shd_pkg::POS_CSUM: begin
                    n_pos = shd_pkg::POS_HUNT;
                    if (i_byte == r_sum) begin
                        w_good  = 1'b1;
                        n_total = r_total + 32'd1;
                    end
                end
                default: begin
                    n_pos = shd_pkg::POS_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= shd_pkg::POS_HUNT;
            r_total <= 32'd0;
        end else begin
            r_pos   <= n_pos;
            r_total <= n_total;
        end
        r_sum  <= n_sum;
        r_flag <= n_flag;
        r_x    <= n_x;
        r_y    <= n_y;
    end

    assign o_status.last = (r_pos == shd_pkg::POS_CSUM);
    assign o_status.good = w_good;

    assign o_result.target_valid = (r_flag == shd_pkg::FLAG_TARGET);
    assign o_result.x_position   = $signed(r_x);
    assign o_result.y_position   = r_y;
    assign o_result.frame_count  = n_total;

endmodule

// ===== rtl/core/shd_out_reg.sv =====
module shd_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  shd_pkg::t_result     i_result,
    input  logic                 i_ready,
    output logic                 o_valid,
    output shd_pkg::t_result     o_result
);

    logic             r_valid;
    shd_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/sync_header_packet_deframer.sv =====
// Serial frame deframer: takes one received byte per beat on i_rx and hunts
// for an 8-byte frame (0xAA, 0x55, flag, x low, x high, y low, y high, sum).
// The sum byte must equal the modulo-256 sum of the first seven bytes; a good
// frame gives one result beat on o_res carrying target_valid (flag == 1),
// signed x, unsigned y and the running count of good frames (wraps at 2^32).
// Bad frames vanish without trace. A second 0xAA in place of 0x55 restarts
// the header; any other byte there drops back to hunting. Rate: one byte per
// clock, sustained; a running checksum and field capture sit between the
// position register and the one-deep result register, so the result of a
// frame appears the cycle after its checksum byte. Input stalls only when the
// checksum byte is due while an earlier result still waits on o_res.
module sync_header_packet_deframer (
    input logic      i_clk,
    input logic      i_rst_n,
    shd_rx_if.sink   i_rx,
    shd_res_if.source o_res
);

    shd_pkg::t_asm_status w_status;
    shd_pkg::t_result     w_result;
    shd_pkg::t_result     w_out;
    logic                 w_accept;
    logic                 w_out_valid;

    // Only the checksum beat can produce a result, so any other byte is
    // taken even while the result register is still full.
    assign i_rx.ready = !w_status.last || !w_out_valid || o_res.ready;
    assign w_accept   = i_rx.valid && i_rx.ready;

    shd_frame_asm u_asm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_rx.rx_byte),
        .o_status (w_status),
        .o_result (w_result)
    );

    // Result register: loads on a good checksum beat, frees on a taken beat.
    shd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_status.good),
        .i_result (w_result),
        .i_ready  (o_res.ready),
        .o_valid  (w_out_valid),
        .o_result (w_out)
    );

    assign o_res.valid        = w_out_valid;
    assign o_res.target_valid = w_out.target_valid;
    assign o_res.x_position   = w_out.x_position;
    assign o_res.y_position   = w_out.y_position;
    assign o_res.frame_count  = w_out.frame_count;

endmodule

// ===== rtl/core/shd_checker.sv =====
`include "assert_macros.svh"

module shd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        i_rx_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [15:0] i_res_x,
    input logic [31:0] i_res_count
);

    property p_res_hold;
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_count) && $stable(i_res_x);
    endproperty

    property p_res_cause;
        $rose(i_res_valid) |-> $past(i_rx_valid && i_rx_ready);
    endproperty

    property p_rx_stall;
        !i_rx_ready |-> i_res_valid && !i_res_ready;
    endproperty

    // Held result beat keeps its x position and frame count
    `SHD_ASSERT(a_res_hold, i_clk, i_rst_n, p_res_hold, "result beat changed while stalled")

    // No result beat straight after reset
    `SHD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_res_valid, "result valid after reset")

    // A fresh result follows an accepted byte
    `SHD_ASSERT(a_res_cause, i_clk, i_rst_n, p_res_cause, "result without input beat")

    // Input only stalls behind a blocked result
    `SHD_ASSERT(a_rx_stall, i_clk, i_rst_n, p_rx_stall, "input stalled with output free")

endmodule

bind sync_header_packet_deframer shd_checker u_shd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_valid  (i_rx.valid),
    .i_rx_ready  (i_rx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_x     (o_res.x_position),
    .i_res_count (o_res.frame_count)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Receive beat as queued for the driver; hold_for_drain makes the driver
    // wait until every predicted result has come out before presenting it.
    typedef struct {
        shd_pkg::t_byte value;
        bit             hold_for_drain;
    } t_rx_beat;

    localparam int STALL_LIMIT  = 2000; // cycles with no beat on either side
    localparam int RANDOM_BEATS = 400;
    localparam int IDLE_PCT     = 13;
    // Window of cycles in which neither side idles
    localparam int CALM_FROM    = 200;
    localparam int CALM_TO      = 350;

    logic clk = 1'b0;
    logic rst_n;

    shd_rx_if  rx_bus ();
    shd_res_if res_bus ();

    sync_header_packet_deframer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_bus),
        .o_res   (res_bus)
    );

    // Stimulus and scoreboard storage
    t_rx_beat         rx_plan[$];      // beats still to be driven
    shd_pkg::t_result frames_due[$];   // decoded frames not yet seen on o_res
    int               beats_planned = 0;
    int               beats_taken   = 0;
    int               errors        = 0;
    int               cycle_no      = 0;
    int               quiet_cycles  = 0;
    logic             calm;

    // Predictor state: where we are in the frame, the bytes so far and the
    // running count of frames that passed their checksum.
    shd_pkg::t_pos  hunt_pos;
    shd_pkg::t_byte frame_buf [0:7];
    logic [31:0]    good_frames;

    assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

    always begin
        #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
    end

    // ------------------------------------------------------------------
    // Predictor: consumes one accepted byte, may queue one decoded frame
    // ------------------------------------------------------------------
    task automatic track_beat(input shd_pkg::t_byte b);
        shd_pkg::t_byte   sum;
        shd_pkg::t_result frame;
        case (hunt_pos)
            shd_pkg::POS_HUNT: begin
                // Anything other than the first header byte is dropped
                if (b == shd_pkg::HDR_FIRST) begin
                    frame_buf[shd_pkg::POS_HUNT] = b;
                    hunt_pos = shd_pkg::POS_HDR2;
                end
            end
            shd_pkg::POS_HDR2: begin
                if (b == shd_pkg::HDR_SECOND) begin
                    frame_buf[shd_pkg::POS_HDR2] = b;
                    hunt_pos = shd_pkg::POS_FLAG;
                end else if (b == shd_pkg::HDR_FIRST) begin
                    // repeated 0xAA: treat as a fresh first header byte
                    frame_buf[shd_pkg::POS_HUNT] = b;
                end else begin
                    // broken header, byte not looked at again
                    hunt_pos = shd_pkg::POS_HUNT;
                end
            end
            default: begin
                frame_buf[hunt_pos] = b;
                if (hunt_pos != shd_pkg::POS_CSUM) begin
                    hunt_pos = shd_pkg::t_pos'(hunt_pos + 1);
                end else begin
                    hunt_pos = shd_pkg::POS_HUNT;
                    sum = '0;
                    for (int k = 0; k < shd_pkg::POS_CSUM; k++)
                        sum = shd_pkg::t_byte'(sum + frame_buf[k]);
                    // bad sum: frame vanishes, count unchanged
                    if (sum == frame_buf[shd_pkg::POS_CSUM]) begin
                        good_frames = good_frames + 1;
                        frame.target_valid = (frame_buf[shd_pkg::POS_FLAG] ==
                                              shd_pkg::FLAG_TARGET);
                        frame.x_position   = {frame_buf[shd_pkg::POS_XHI],
                                              frame_buf[shd_pkg::POS_XLO]};
                        frame.y_position   = {frame_buf[shd_pkg::POS_YHI],
                                              frame_buf[shd_pkg::POS_YLO]};
                        frame.frame_count  = good_frames;
                        frames_due.push_back(frame);
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued beats on i_rx, idling at random
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        logic     fire;
        logic     idle;
        t_rx_beat nxt;
        if (!rst_n) begin
            rx_bus.valid <= 1'b0;
            hunt_pos    = shd_pkg::POS_HUNT;
            good_frames = '0;
            foreach (frame_buf[k])
                frame_buf[k] = '0;
        end else begin
            fire = rx_bus.valid && rx_bus.ready;
            if (fire) begin
                track_beat(rx_bus.rx_byte);
                beats_taken++;
            end
            // Only move on once the current beat is gone (or nothing is up)
            if (fire || !rx_bus.valid) begin
                idle = !calm && ($urandom_range(0, 99) < IDLE_PCT);
                if (rx_plan.size() != 0 && !idle &&
                    !(rx_plan[0].hold_for_drain && frames_due.size() != 0)) begin
                    nxt = rx_plan.pop_front();
                    rx_bus.valid   <= 1'b1;
                    rx_bus.rx_byte <= nxt.value;
                end else begin
                    rx_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes result beats off o_res and checks them in order
    // ------------------------------------------------------------------
    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, label, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        shd_pkg::t_result want;
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected result beat, got %b %h %h %h", $time,
                             res_bus.target_valid, res_bus.x_position,
                             res_bus.y_position, res_bus.frame_count);
                    errors++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("target_valid", 32'(want.target_valid),
                                32'(res_bus.target_valid));
                    check_field("x_position", 32'(unsigned'(want.x_position)),
                                32'(unsigned'(res_bus.x_position)));
                    check_field("y_position", 32'(want.y_position),
                                32'(res_bus.y_position));
                    check_field("frame_count", want.frame_count, res_bus.frame_count);
                end
            end
            res_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: too long without a beat on either channel means a hang
    always @(posedge clk) begin
        if (rst_n) begin
            if ((rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("sync_header_packet_deframer: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic plan_byte(input shd_pkg::t_byte v, input bit drain = 1'b0);
        t_rx_beat beat;
        beat.value          = v;
        beat.hold_for_drain = drain;
        rx_plan.push_back(beat);
        beats_planned++;
    endtask

    // Whole frame with header; a corrupt frame has its sum byte knocked off
    task automatic plan_frame(input shd_pkg::t_byte flag, input logic [15:0] x,
                              input logic [15:0] y, input bit corrupt,
                              input bit drain = 1'b0);
        shd_pkg::t_byte sum;
        sum = shd_pkg::t_byte'(shd_pkg::HDR_FIRST + shd_pkg::HDR_SECOND + flag +
                               x[7:0] + x[15:8] + y[7:0] + y[15:8]);
        if (corrupt)
            sum = shd_pkg::t_byte'(sum + $urandom_range(1, 255));
        plan_byte(shd_pkg::HDR_FIRST, drain);
        plan_byte(shd_pkg::HDR_SECOND);
        plan_byte(flag);
        plan_byte(x[7:0]);
        plan_byte(x[15:8]);
        plan_byte(y[7:0]);
        plan_byte(y[15:8]);
        plan_byte(sum);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int             start_size;
        int             frame_no;
        int             kind;
        shd_pkg::t_byte flag;

        rst_n = 1'b0;

        // Directed: noise while hunting, a stray 0x55 with no header
        plan_byte(8'h00);
        plan_byte(8'hFF);
        plan_byte(shd_pkg::HDR_SECOND);
        // Doubled 0xAA restarts the header; most negative x, largest y
        plan_byte(shd_pkg::HDR_FIRST);
        plan_frame(shd_pkg::FLAG_TARGET, 16'h8000, 16'hFFFF, 1'b0);
        // Broken header: 0xAA then junk drops back to hunting
        plan_byte(shd_pkg::HDR_FIRST);
        plan_byte(8'h12);
        // Bad checksum is swallowed
        plan_frame(8'h00, 16'h7FFF, 16'h0000, 1'b1);
        // Flag other than one still yields a result, with valid low
        plan_frame(8'hFF, 16'hFFFF, 16'h0000, 1'b0);

        // Random part: mostly good frames, some bad sums, noise and
        // broken headers mixed in.
        start_size = beats_planned;
        frame_no   = 0;
        while (beats_planned - start_size < RANDOM_BEATS) begin
            kind = $urandom_range(0, 99);
            flag = ($urandom_range(0, 1) != 0) ? shd_pkg::FLAG_TARGET
                                               : shd_pkg::t_byte'($urandom);
            if (kind < 70) begin
                // one pause for a full drain part way through
                plan_frame(flag, pick_word(), pick_word(), 1'b0, frame_no == 20);
                frame_no++;
            end else if (kind < 82) begin
                plan_frame(flag, pick_word(), pick_word(), 1'b1);
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 4))
                    plan_byte(shd_pkg::t_byte'($urandom));
            end else if (kind < 94) begin
                plan_byte(shd_pkg::HDR_FIRST);
                plan_frame(flag, pick_word(), pick_word(), 1'b0);
            end else begin
                plan_byte(shd_pkg::HDR_FIRST);
                plan_byte(shd_pkg::t_byte'($urandom_range(0, 8'h54)));
            end
        end

        // Synchronous reset, then release
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_taken != beats_planned)
            @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        // let any late or spurious result show up
        repeat (20) @(posedge clk);

        if (errors == 0) begin
            $display("sync_header_packet_deframer: match");
        end else begin
            $display("sync_header_packet_deframer: mismatch");
        end
        $finish;
    end

endmodule
